// File: rtl/core/heightmap_area_min_max_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the heightmap area min/max block
// Shorthand for clocked assertions that are disabled while reset is active.
// ---------------------------------------------------------------------------
`ifndef HEIGHTMAP_AREA_MIN_MAX_TOP_MACROS_SVH
`define HEIGHTMAP_AREA_MIN_MAX_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define HAMM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies a consequence on the same edge
`define HAMM_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence on the next edge
`define HAMM_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/hamm_pkg.sv
// ---------------------------------------------------------------------------
// hamm_pkg
// Widths, reset values, codes and the height conversion for the heightmap
// area min/max block.
// ---------------------------------------------------------------------------
`default_nettype none

package hamm_pkg;

    // Map geometry
    localparam int MAX_MAP_SIDE = 512;
    localparam int SIDE_W       = $clog2(MAX_MAP_SIDE + 1);
    localparam int COORD_W      = $clog2(MAX_MAP_SIDE);
    localparam int ADDR_W       = 2 * COORD_W;
    localparam int STORE_DEPTH  = MAX_MAP_SIDE * MAX_MAP_SIDE;

    // Fixed point of query coordinates and of the scale factor
    localparam int FRAC_BITS   = 8;
    localparam int SCALE_SHIFT = 2 * FRAC_BITS;
    localparam int COORD_IN_W  = 20;
    localparam int SCALE_W     = 12;
    localparam int PROD_W      = COORD_IN_W + SCALE_W;
    localparam int INT_W       = PROD_W - SCALE_SHIFT;
    localparam int CNT_W       = INT_W + 1;

    // Item fields and ports
    localparam int SIZE_W      = 10;
    localparam int INDEX_W     = 18;
    localparam int BYTE_W      = 8;
    localparam int HEIGHT_W    = 13;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;

    // Register reset values
    localparam logic [SIZE_W-1:0]  WIDTH_RESET  = SIZE_W'(512);
    localparam logic [SIZE_W-1:0]  HEIGHT_RESET = SIZE_W'(512);
    localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(1311);

    // Running extremes start values
    localparam logic [BYTE_W-1:0] CODE_LOW  = '0;
    localparam logic [BYTE_W-1:0] CODE_HIGH = '1;

    // Height conversion constants: height = 20*c + (20*c + 127)/255 - 2560
    localparam logic [15:0] HEIGHT_GAIN   = 16'd20;
    localparam logic [15:0] HEIGHT_ROUND  = 16'd127;
    localparam logic [15:0] HEIGHT_OFFSET = 16'd2560;

    // Request kinds carried on the input user bit
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH  = 2'd0,
        REG_MAP_HEIGHT = 2'd1,
        REG_AREA_SCALE = 2'd2
    } cfg_reg_t;

    // Signed Q.8 height of a texel code, rounded to nearest
    function automatic logic signed [HEIGHT_W-1:0] height_of(input logic [BYTE_W-1:0] code);
        logic [15:0] base;
        logic [15:0] num;
        logic [15:0] quot;
        logic [15:0] sum;
        base = 16'(code) * HEIGHT_GAIN;
        num  = base + HEIGHT_ROUND;
        // divide by 255 through x/255 = (x + 1 + x/256) / 256, exact for x < 65535
        quot = (num + 16'd1 + (num >> 8)) >> 8;
        sum  = base + quot - HEIGHT_OFFSET;
        return $signed(sum[HEIGHT_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/heightmap_area_min_max_top.sv
// Heightmap area min/max search.
// Input channel s_axis: one item per request. tuser = 0 loads one texel byte
// into the map store at load_index; it gives no result.
// tuser = 1 asks for the least and greatest texel code (byte plus one, mod
// 256) over a rectangle whose start and extent are scaled by area_scale.
// Output channel m_axis: one item per query, held in an output register
// until taken; tuser flags an area that covers no texel (all data zero).
// A query scales its coordinates on the shared multiplier, runs a
// bit-serial modulo for the wrapped start column and row, then reads one
// texel a cycle through the single read port of the map store. An empty
// area answers without a walk, straight from the extent check.
// The block takes no new item from accept until its result is taken; a
// stalled receiver holds the block with the result on m_axis.
// Reset restores the map size and scale registers and clears the sequencer;
// the map store keeps its contents and texels must be loaded before they
// are searched. cfg_we writes register cfg_index (0 width, 1 height,
// 2 scale) from cfg_data; write only while no query is in flight.
`default_nettype none

`include "heightmap_area_min_max_top_macros.svh"

module heightmap_area_min_max_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // lowest bit up: load_index, load_value, x_start, z_start, x_extent,
    // z_extent, zero fill
    input  wire logic [hamm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // req_type
    input  wire logic                              s_axis_tuser,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // lowest bit up: max_code, min_code, max_height, min_height, zero fill
    output logic [hamm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // area_empty
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic                              cfg_we,
    input  wire logic [hamm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hamm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hamm_pkg::*;

    localparam int MOD_CNT_W = $clog2(INT_W);
    localparam int MUL_STEPS = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_MOD,
        ST_ZW,
        ST_BASE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        P_XS,
        P_ZS,
        P_XW,
        P_ZH
    } prod_sel_t;

    // Input fields
    logic [INDEX_W-1:0]    in_load_index;
    logic [BYTE_W-1:0]     in_load_value;
    logic [COORD_IN_W-1:0] in_x_start;
    logic [COORD_IN_W-1:0] in_z_start;
    logic [COORD_IN_W-1:0] in_x_extent;
    logic [COORD_IN_W-1:0] in_z_extent;

    assign in_load_index = s_axis_tdata[17:0];
    assign in_load_value = s_axis_tdata[25:18];
    assign in_x_start    = s_axis_tdata[45:26];
    assign in_z_start    = s_axis_tdata[65:46];
    assign in_x_extent   = s_axis_tdata[85:66];
    assign in_z_extent   = s_axis_tdata[105:86];

    // Control and configuration
    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   width_cfg_reg, height_cfg_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [SIDE_W-1:0]   w_side, h_side;

    // Latched query coordinates
    logic [COORD_IN_W-1:0] xs_in_reg, xs_in_next;
    logic [COORD_IN_W-1:0] zs_in_reg, zs_in_next;
    logic [COORD_IN_W-1:0] xw_in_reg, xw_in_next;
    logic [COORD_IN_W-1:0] zh_in_reg, zh_in_next;

    // Shared multiplier
    logic [2:0]            mul_cnt_reg, mul_cnt_next;
    logic [COORD_IN_W-1:0] mul_a;
    logic [SCALE_W-1:0]    mul_b;
    logic [PROD_W-1:0]     mul_p;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    prod_sel_t             prod_sel_reg, prod_sel_next;
    logic                  prod_vld_reg, prod_vld_next;

    // Scaled integer parts and walk lengths
    logic [INT_W-1:0] xq_reg, xq_next, zq_reg, zq_next;
    logic [CNT_W-1:0] ncol_reg, ncol_next, nrow_reg, nrow_next;

    // Bit-serial modulo
    logic                 mod_sel_reg, mod_sel_next;
    logic [MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;
    logic [INT_W-1:0]     div_reg, div_next;
    logic [SIDE_W-1:0]    rem_reg, rem_next;
    logic [SIDE_W:0]      mod_trial;
    logic [SIDE_W-1:0]    mod_div;
    logic [SIDE_W-1:0]    mod_rem;

    // Walk
    logic [COORD_W-1:0] x0_reg, x0_next, z0_reg, z0_next;
    logic [COORD_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [ADDR_W-1:0]  row_base_reg, row_base_next;
    logic [SIDE_W-1:0]  col_step_reg, col_step_next, row_step_reg, row_step_next;
    logic [ADDR_W-1:0]  rd_addr;
    logic [BYTE_W-1:0]  rd_data_reg;
    logic               rd_vld_reg, rd_vld_next;
    logic [BYTE_W-1:0]  rd_code;
    logic [BYTE_W-1:0]  max_reg, max_next, min_reg, min_next;

    // Result register
    logic [BYTE_W-1:0]          out_max_reg, out_max_next, out_min_reg, out_min_next;
    logic signed [HEIGHT_W-1:0] out_maxh_reg, out_maxh_next, out_minh_reg, out_minh_next;
    logic                       out_empty_reg, out_empty_next;
    logic                       out_vld_reg, out_vld_next;

    // Map store
    logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
    logic              s_accept;
    logic              load_we;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign load_we  = s_accept && (s_axis_tuser == REQ_LOAD)
                      && (32'(in_load_index) < 32'(STORE_DEPTH));

    // Effective map sides: zero acts as one, oversize clamps
    always_comb
    begin
        if (width_cfg_reg == '0)
            w_side = SIDE_W'(1);
        else if (32'(width_cfg_reg) > 32'(MAX_MAP_SIDE))
            w_side = SIDE_W'(MAX_MAP_SIDE);
        else
            w_side = SIDE_W'(width_cfg_reg);

        if (height_cfg_reg == '0)
            h_side = SIDE_W'(1);
        else if (32'(height_cfg_reg) > 32'(MAX_MAP_SIDE))
            h_side = SIDE_W'(MAX_MAP_SIDE);
        else
            h_side = SIDE_W'(height_cfg_reg);
    end

    // Select multiplier operands: scaling steps, then start row times width
    always_comb
    begin
        mul_b = scale_reg;
        case (prod_sel_t'(mul_cnt_reg[1:0]))
            P_XS:    mul_a = xs_in_reg;
            P_ZS:    mul_a = zs_in_reg;
            P_XW:    mul_a = xw_in_reg;
            P_ZH:    mul_a = zh_in_reg;
            default: mul_a = xs_in_reg;
        endcase
        if (state_reg == ST_ZW)
        begin
            mul_a = COORD_IN_W'(z0_reg);
            mul_b = SCALE_W'(w_side);
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // One restoring step of the modulo
    assign mod_div   = mod_sel_reg ? h_side : w_side;
    assign mod_trial = {rem_reg, div_reg[INT_W-1]};
    assign mod_rem   = (mod_trial >= (SIDE_W+1)'(mod_div))
                       ? SIDE_W'(mod_trial - (SIDE_W+1)'(mod_div))
                       : SIDE_W'(mod_trial);

    assign rd_addr = ADDR_W'(col_reg) + row_base_reg;
    assign rd_code = rd_data_reg + BYTE_W'(1);

    // Write loads and read the walk address
    always_ff @(posedge clk)
    begin
        if (load_we)
            store_mem[ADDR_W'(in_load_index)] <= in_load_value;
        rd_data_reg <= store_mem[rd_addr];
    end

    // Sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        xs_in_next    = xs_in_reg;
        zs_in_next    = zs_in_reg;
        xw_in_next    = xw_in_reg;
        zh_in_next    = zh_in_reg;
        mul_cnt_next  = mul_cnt_reg;
        prod_next     = prod_reg;
        prod_sel_next = prod_sel_reg;
        prod_vld_next = 1'b0;
        xq_next       = xq_reg;
        zq_next       = zq_reg;
        ncol_next     = ncol_reg;
        nrow_next     = nrow_reg;
        mod_sel_next  = mod_sel_reg;
        mod_cnt_next  = mod_cnt_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        x0_next       = x0_reg;
        z0_next       = z0_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        col_step_next = col_step_reg;
        row_step_next = row_step_reg;
        rd_vld_next   = 1'b0;
        max_next      = max_reg;
        min_next      = min_reg;
        out_max_next  = out_max_reg;
        out_min_next  = out_min_reg;
        out_maxh_next = out_maxh_reg;
        out_minh_next = out_minh_reg;
        out_empty_next = out_empty_reg;
        out_vld_next  = out_vld_reg;

        // Capture a registered product
        if (prod_vld_reg)
        begin
            case (prod_sel_reg)
                P_XS:    xq_next = prod_reg[PROD_W-1:SCALE_SHIFT];
                P_ZS:    zq_next = prod_reg[PROD_W-1:SCALE_SHIFT];
                P_XW:    ncol_next = CNT_W'(prod_reg[PROD_W-1:SCALE_SHIFT])
                                     + CNT_W'(|prod_reg[SCALE_SHIFT-1:0]);
                P_ZH:    nrow_next = CNT_W'(prod_reg[PROD_W-1:SCALE_SHIFT])
                                     + CNT_W'(|prod_reg[SCALE_SHIFT-1:0]);
                default: ;
            endcase
        end

        // Fold each fetched texel into the running extremes
        if (rd_vld_reg)
        begin
            if (rd_code > max_reg)
                max_next = rd_code;
            if (rd_code < min_reg)
                min_next = rd_code;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && (s_axis_tuser == REQ_QUERY))
                begin
                    xs_in_next   = in_x_start;
                    zs_in_next   = in_z_start;
                    xw_in_next   = in_x_extent;
                    zh_in_next   = in_z_extent;
                    mul_cnt_next = '0;
                    state_next   = ST_MUL;
                end
            end

            ST_MUL:
            begin
                if (mul_cnt_reg < 3'(MUL_STEPS))
                begin
                    prod_next     = mul_p;
                    prod_sel_next = prod_sel_t'(mul_cnt_reg[1:0]);
                    prod_vld_next = 1'b1;
                    mul_cnt_next  = mul_cnt_reg + 3'd1;
                end
                else
                    state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if ((ncol_reg == '0) || (nrow_reg == '0))
                begin
                    out_max_next   = '0;
                    out_min_next   = '0;
                    out_maxh_next  = '0;
                    out_minh_next  = '0;
                    out_empty_next = 1'b1;
                    out_vld_next   = 1'b1;
                    state_next     = ST_OUT;
                end
                else
                begin
                    // Walks beyond one full turn repeat texels already seen
                    if (ncol_reg > CNT_W'(w_side))
                        ncol_next = CNT_W'(w_side);
                    if (nrow_reg > CNT_W'(h_side))
                        nrow_next = CNT_W'(h_side);
                    mod_sel_next = 1'b0;
                    mod_cnt_next = '0;
                    div_next     = xq_reg;
                    rem_next     = '0;
                    state_next   = ST_MOD;
                end
            end

            ST_MOD:
            begin
                div_next     = div_reg << 1;
                rem_next     = mod_rem;
                mod_cnt_next = mod_cnt_reg + MOD_CNT_W'(1);
                if (mod_cnt_reg == MOD_CNT_W'(INT_W - 1))
                begin
                    if (!mod_sel_reg)
                    begin
                        x0_next      = mod_rem[COORD_W-1:0];
                        mod_sel_next = 1'b1;
                        mod_cnt_next = '0;
                        div_next     = zq_reg;
                        rem_next     = '0;
                    end
                    else
                    begin
                        z0_next    = mod_rem[COORD_W-1:0];
                        state_next = ST_ZW;
                    end
                end
            end

            ST_ZW:
            begin
                prod_next     = mul_p;
                col_next      = x0_reg;
                row_next      = z0_reg;
                col_step_next = '0;
                row_step_next = '0;
                max_next      = CODE_LOW;
                min_next      = CODE_HIGH;
                state_next    = ST_BASE;
            end

            ST_BASE:
            begin
                row_base_next = prod_reg[ADDR_W-1:0];
                state_next    = ST_WALK;
            end

            ST_WALK:
            begin
                rd_vld_next = 1'b1;
                if ((row_step_reg + SIDE_W'(1)) == nrow_reg[SIDE_W-1:0])
                begin
                    // Column done: back to the start row, advance column
                    row_step_next = '0;
                    row_next      = z0_reg;
                    row_base_next = prod_reg[ADDR_W-1:0];
                    if ((col_step_reg + SIDE_W'(1)) == ncol_reg[SIDE_W-1:0])
                        state_next = ST_DRAIN;
                    else
                    begin
                        col_step_next = col_step_reg + SIDE_W'(1);
                        if ((SIDE_W'(col_reg) + SIDE_W'(1)) == w_side)
                            col_next = '0;
                        else
                            col_next = col_reg + COORD_W'(1);
                    end
                end
                else
                begin
                    row_step_next = row_step_reg + SIDE_W'(1);
                    if ((SIDE_W'(row_reg) + SIDE_W'(1)) == h_side)
                    begin
                        row_next      = '0;
                        row_base_next = '0;
                    end
                    else
                    begin
                        row_next      = row_reg + COORD_W'(1);
                        row_base_next = row_base_reg + ADDR_W'(w_side);
                    end
                end
            end

            ST_DRAIN:
                state_next = ST_FINISH;

            ST_FINISH:
            begin
                out_max_next   = max_reg;
                out_min_next   = min_reg;
                out_maxh_next  = height_of(max_reg);
                out_minh_next  = height_of(min_reg);
                out_empty_next = 1'b0;
                out_vld_next   = 1'b1;
                state_next     = ST_OUT;
            end

            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    out_vld_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // Hold control state, configuration and the result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
            scale_reg      <= SCALE_RESET;
            mul_cnt_reg    <= '0;
            prod_vld_reg   <= 1'b0;
            mod_sel_reg    <= 1'b0;
            mod_cnt_reg    <= '0;
            col_step_reg   <= '0;
            row_step_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            max_reg        <= CODE_LOW;
            min_reg        <= CODE_HIGH;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mul_cnt_reg  <= mul_cnt_next;
            prod_vld_reg <= prod_vld_next;
            mod_sel_reg  <= mod_sel_next;
            mod_cnt_reg  <= mod_cnt_next;
            col_step_reg <= col_step_next;
            row_step_reg <= row_step_next;
            rd_vld_reg   <= rd_vld_next;
            max_reg      <= max_next;
            min_reg      <= min_next;
            out_vld_reg  <= out_vld_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_MAP_WIDTH:  width_cfg_reg  <= cfg_data[SIZE_W-1:0];
                    REG_MAP_HEIGHT: height_cfg_reg <= cfg_data[SIZE_W-1:0];
                    REG_AREA_SCALE: scale_reg      <= cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Advance payload registers
    always_ff @(posedge clk)
    begin
        xs_in_reg     <= xs_in_next;
        zs_in_reg     <= zs_in_next;
        xw_in_reg     <= xw_in_next;
        zh_in_reg     <= zh_in_next;
        prod_reg      <= prod_next;
        prod_sel_reg  <= prod_sel_next;
        xq_reg        <= xq_next;
        zq_reg        <= zq_next;
        ncol_reg      <= ncol_next;
        nrow_reg      <= nrow_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        x0_reg        <= x0_next;
        z0_reg        <= z0_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        row_base_reg  <= row_base_next;
        out_max_reg   <= out_max_next;
        out_min_reg   <= out_min_next;
        out_maxh_reg  <= out_maxh_next;
        out_minh_reg  <= out_minh_next;
        out_empty_reg <= out_empty_next;
    end

    // Drive the channels
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_empty_reg;
    assign m_axis_tdata  = {6'b0, out_minh_reg, out_maxh_reg, out_min_reg, out_max_reg};

    // Checks
    `HAMM_ASSERT_IMPL(a_no_input_while_result, out_vld_reg, !s_axis_tready,
        "input taken while a result is pending")
    `HAMM_ASSERT_IMPL(a_min_not_above_max, out_vld_reg && !out_empty_reg,
        out_min_reg <= out_max_reg, "result minimum above maximum")
    `HAMM_ASSERT_IMPL(a_walk_in_map, state_reg == ST_WALK,
        (SIDE_W'(col_reg) < w_side) && (SIDE_W'(row_reg) < h_side),
        "walk position outside the map")
    `HAMM_ASSERT_NEXT(a_read_follows_walk, state_reg != ST_WALK, !rd_vld_reg,
        "texel read without a walk step")

endmodule

`default_nettype wire

// File: test/area_extremes_checker.sv
// ----------------------------------------------------------------------------
// Area extremes checker
// Watches the item, result and register channels of the heightmap area
// min/max block. It keeps its own copy of the texel store and registers,
// works out the least and greatest code of every query as it is accepted,
// and compares each result item field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module area_extremes_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [hamm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [hamm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                m_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_we,
    input  logic [hamm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hamm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int unsigned                         mismatch_count,
    output int unsigned                         results_owed,
    output int unsigned                         loads_seen,
    output int unsigned                         queries_seen,
    output int unsigned                         empty_seen,
    output int unsigned                         results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import hamm_pkg::*;

    typedef struct packed {
        logic [7:0]         max_code;
        logic [7:0]         min_code;
        logic signed [12:0] max_height;
        logic signed [12:0] min_height;
        logic               area_empty;
    } area_result_t;

    // Shadow of the block's registers and texel store
    logic [SIZE_W-1:0]  cols_reg;
    logic [SIZE_W-1:0]  rows_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [7:0]         texel_copy [0:STORE_DEPTH-1];

    area_result_t awaited_results[$];
    area_result_t got;
    area_result_t want;

    task automatic log_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Clamp a size register to the sides the store supports
    function automatic int unsigned side_limit(input logic [SIZE_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > MAX_MAP_SIDE)
            return MAX_MAP_SIDE;
        return r;
    endfunction

    // Signed Q.8 height of a code, rounded to nearest
    function automatic logic signed [12:0] code_height(input logic [7:0] c);
        int h;
        h = (5120 * int'(c) + 127) / 255 - 2560;
        return h[12:0];
    endfunction

    // Walk the scaled rectangle over the wrapped map and keep the extremes
    function automatic area_result_t find_area_extremes(input logic [19:0] xs,
                                                        input logic [19:0] zs,
                                                        input logic [19:0] xe,
                                                        input logic [19:0] ze);
        area_result_t     r;
        longint unsigned  ncol;
        longint unsigned  nrow;
        longint unsigned  c;
        longint unsigned  k;
        int unsigned      cols;
        int unsigned      rows;
        int unsigned      x0;
        int unsigned      z0;
        int unsigned      addr;
        logic [7:0]       code;
        logic [7:0]       hi;
        logic [7:0]       lo;
        r    = '0;
        cols = side_limit(cols_reg);
        rows = side_limit(rows_reg);
        ncol = (64'(xe) * 64'(scale_reg) + 64'hFFFF) >> SCALE_SHIFT;
        nrow = (64'(ze) * 64'(scale_reg) + 64'hFFFF) >> SCALE_SHIFT;
        if (ncol == 0 || nrow == 0)
        begin
            r.area_empty = 1'b1;
            return r;
        end
        // more than one turn only revisits texels
        if (ncol > cols)
            ncol = cols;
        if (nrow > rows)
            nrow = rows;
        x0 = int'(((64'(xs) * 64'(scale_reg)) >> SCALE_SHIFT) % cols);
        z0 = int'(((64'(zs) * 64'(scale_reg)) >> SCALE_SHIFT) % rows);
        hi = 8'd0;
        lo = 8'hFF;
        for (c = 0; c < ncol; c++)
        begin
            for (k = 0; k < nrow; k++)
            begin
                addr = (x0 + int'(c)) % cols + ((z0 + int'(k)) % rows) * cols;
                code = texel_copy[addr] + 8'd1;
                if (code > hi)
                    hi = code;
                if (code < lo)
                    lo = code;
            end
        end
        r.max_code   = hi;
        r.min_code   = lo;
        r.max_height = code_height(hi);
        r.min_height = code_height(lo);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cols_reg  = WIDTH_RESET;
            rows_reg  = HEIGHT_RESET;
            scale_reg = SCALE_RESET;
            awaited_results.delete();
            results_owed = 0;
        end
        else
        begin
            // Compare a taken result with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got.max_code   = m_axis_tdata[7:0];
                got.min_code   = m_axis_tdata[15:8];
                got.max_height = m_axis_tdata[28:16];
                got.min_height = m_axis_tdata[41:29];
                got.area_empty = m_axis_tuser;
                if (awaited_results.size() == 0)
                    log_mismatch($sformatf("result %0d arrived with no query waiting",
                                           results_seen));
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.area_empty)
                        empty_seen++;
                    if (got.max_code !== want.max_code)
                        log_mismatch($sformatf("result %0d max_code %0d, predicted %0d",
                                               results_seen, got.max_code, want.max_code));
                    if (got.min_code !== want.min_code)
                        log_mismatch($sformatf("result %0d min_code %0d, predicted %0d",
                                               results_seen, got.min_code, want.min_code));
                    if (got.max_height !== want.max_height)
                        log_mismatch($sformatf("result %0d max_height %0d, predicted %0d",
                                               results_seen, got.max_height,
                                               want.max_height));
                    if (got.min_height !== want.min_height)
                        log_mismatch($sformatf("result %0d min_height %0d, predicted %0d",
                                               results_seen, got.min_height,
                                               want.min_height));
                    if (got.area_empty !== want.area_empty)
                        log_mismatch($sformatf("result %0d area_empty %0b, predicted %0b",
                                               results_seen, got.area_empty,
                                               want.area_empty));
                end
            end

            // Track register writes
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_MAP_WIDTH:  cols_reg  = cfg_data[SIZE_W-1:0];
                    REG_MAP_HEIGHT: rows_reg  = cfg_data[SIZE_W-1:0];
                    REG_AREA_SCALE: scale_reg = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end

            // Apply a load or predict a query on every accepted item
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == REQ_LOAD)
                begin
                    loads_seen++;
                    texel_copy[s_axis_tdata[17:0]] = s_axis_tdata[25:18];
                end
                else
                begin
                    queries_seen++;
                    awaited_results.push_back(find_area_extremes(s_axis_tdata[45:26],
                                                                 s_axis_tdata[65:46],
                                                                 s_axis_tdata[85:66],
                                                                 s_axis_tdata[105:86]));
                end
            end
            results_owed = awaited_results.size();
        end
    end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Heightmap area min/max testbench
// Loads texels and sends area queries through the item channel under several
// map sizes and scales, with random gaps on both channels and one long
// receiver hold-off. Every texel a query can reach is loaded first. The
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hamm_pkg::*;

    localparam int HALF_PERIOD = 1;
    localparam int HOLD_CYCLES = 400;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic [IN_TDATA_W-1:0]      s_axis_tdata;
    logic                       s_axis_tuser;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                       m_axis_tuser;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int unsigned mismatch_count;
    int unsigned results_owed;
    int unsigned loads_seen;
    int unsigned queries_seen;
    int unsigned empty_seen;
    int unsigned results_seen;

    // Idle rates in percent and the receiver hold-off request
    int unsigned send_idle_pct = 18;
    int unsigned recv_idle_pct = 62;
    bit          hold_armed    = 1'b0;

    // Register values as the block sees them, for preloading
    int unsigned cols_side = 512;
    int unsigned rows_side = 512;
    int unsigned scale_now = 1311;
    bit          texel_loaded [0:STORE_DEPTH-1];

    heightmap_area_min_max_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    area_extremes_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed),
        .loads_seen     (loads_seen),
        .queries_seen   (queries_seen),
        .empty_seen     (empty_seen),
        .results_seen   (results_seen)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one item, with a random gap first, and return after its accept edge
    task automatic push_item(input logic kind, input logic [IN_TDATA_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= word;
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
    endtask

    task automatic send_load(input logic [17:0] idx, input logic [7:0] val);
        texel_loaded[idx] = 1'b1;
        push_item(REQ_LOAD, {6'd0, 20'($urandom), 20'($urandom), 20'($urandom),
                             20'($urandom), val, idx});
    endtask

    // Load every texel the query can reach that was never written
    task automatic preload_area(input logic [19:0] xs, input logic [19:0] zs,
                                input logic [19:0] xe, input logic [19:0] ze);
        longint unsigned ncol;
        longint unsigned nrow;
        longint unsigned c;
        longint unsigned k;
        int unsigned     x0;
        int unsigned     z0;
        int unsigned     addr;
        ncol = (64'(xe) * 64'(scale_now) + 64'hFFFF) >> SCALE_SHIFT;
        nrow = (64'(ze) * 64'(scale_now) + 64'hFFFF) >> SCALE_SHIFT;
        if (ncol > cols_side)
            ncol = cols_side;
        if (nrow > rows_side)
            nrow = rows_side;
        x0 = int'(((64'(xs) * 64'(scale_now)) >> SCALE_SHIFT) % cols_side);
        z0 = int'(((64'(zs) * 64'(scale_now)) >> SCALE_SHIFT) % rows_side);
        for (c = 0; c < ncol; c++)
        begin
            for (k = 0; k < nrow; k++)
            begin
                addr = (x0 + int'(c)) % cols_side + ((z0 + int'(k)) % rows_side) * cols_side;
                if (!texel_loaded[addr])
                    send_load(18'(addr), 8'($urandom));
            end
        end
    endtask

    task automatic send_query(input logic [19:0] xs, input logic [19:0] zs,
                              input logic [19:0] xe, input logic [19:0] ze);
        preload_area(xs, zs, xe, ze);
        push_item(REQ_QUERY, {6'd0, ze, xe, zs, xs, 8'($urandom), 18'($urandom)});
    endtask

    // Drop valid and wait until every result is out and a trailing load is done
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic int unsigned side_of_reg(input logic [11:0] v);
        if (v[9:0] == 0)
            return 1;
        if (v[9:0] > MAX_MAP_SIDE)
            return MAX_MAP_SIDE;
        return v[9:0];
    endfunction

    // Write all three registers on consecutive edges; call only while idle
    task automatic apply_config(input logic [11:0] cols_val, input logic [11:0] rows_val,
                                input logic [11:0] scale_val);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAP_WIDTH;
        cfg_data  <= cols_val;
        @(posedge clk);
        cfg_index <= REG_MAP_HEIGHT;
        cfg_data  <= rows_val;
        @(posedge clk);
        cfg_index <= REG_AREA_SCALE;
        cfg_data  <= scale_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cols_side = side_of_reg(cols_val);
        rows_side = side_of_reg(rows_val);
        scale_now = scale_val;
    endtask

    function automatic logic [19:0] pick_start();
        if ($urandom_range(1) == 0)
            return 20'($urandom_range(4095));
        return 20'($urandom);
    endfunction

    // Some zero; the rest short, or in the full mode up to 600 or anywhere in range
    function automatic logic [19:0] pick_extent(input bit short_areas);
        int unsigned roll;
        roll = $urandom_range(19);
        if (roll == 0)
            return 20'd0;
        if (short_areas)
            return 20'($urandom_range(40));
        if (roll < 10)
            return 20'($urandom_range(600));
        return 20'($urandom);
    endfunction

    // Favor the bytes that land on the extreme codes now and then
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(9) == 0)
            return 8'hFE | 8'($urandom_range(1));
        return 8'($urandom);
    endfunction

    task automatic run_phase(input int unsigned items, input bit short_areas);
        int unsigned n;
        int unsigned idx;
        for (n = 0; n < items; n++)
        begin
            if ($urandom_range(99) < 35)
            begin
                if ($urandom_range(9) < 7)
                    idx = $urandom_range(cols_side * rows_side - 1);
                else
                    idx = 18'($urandom);
                send_load(18'(idx), pick_byte());
            end
            else
                send_query(pick_start(), pick_start(), pick_extent(short_areas),
                           pick_extent(short_areas));
        end
    endtask

    // Stimulus
    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= REQ_LOAD;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_MAP_WIDTH;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty areas, extreme codes, wrapped starts, long walks
        send_query(20'd0, 20'd0, 20'd0, 20'd5);
        send_query(20'd100, 20'd100, 20'd7, 20'd0);
        send_load(18'd0, 8'hFF);
        send_load(18'd1, 8'hFE);
        send_load(18'd2, 8'h00);
        send_load(18'h3FFFF, 8'hA5);
        send_query(20'd0, 20'd0, 20'd1, 20'd1);
        send_query(20'd0, 20'd0, 20'd149, 20'd1);
        send_query('1, '1, 20'd1, 20'd1);
        drain_block();
        // zero width acts as one, oversize height as the largest side
        apply_config(12'd0, 12'd1023, 12'd4095);
        send_query(20'd0, 20'd0, '1, '1);
        send_query('1, 20'd0, '1, 20'd3);
        drain_block();
        apply_config(12'd512, 12'd1, 12'd1);
        send_query('1, '1, '1, '1);
        send_query(20'd0, 20'd0, 20'd1, 20'd1);
        drain_block();

        // Random: sender idles lightly, receiver heavily
        apply_config(12'd16, 12'd8, 12'd1311);
        run_phase(100, 1'b0);
        drain_block();
        apply_config(12'd512, 12'd1, 12'd4095);
        run_phase(90, 1'b0);
        drain_block();

        // Random: sender idles heavily, receiver lightly
        send_idle_pct = 62;
        recv_idle_pct = 18;
        apply_config(12'd1, 12'd512, 12'd1);
        run_phase(90, 1'b0);
        drain_block();
        apply_config(12'd0, 12'd1023, 12'd700);
        run_phase(90, 1'b0);
        drain_block();

        // Random with no idling; hold the receiver off while items keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_config(12'd23, 12'd21, 12'd256);
        hold_armed = 1'b1;
        run_phase(110, 1'b0);
        drain_block();
        // full map, short areas only
        apply_config(12'd512, 12'd512, 12'd4095);
        run_phase(75, 1'b1);
        drain_block();

        repeat (64) @(posedge clk);
        $display("Covered %0d loads and %0d area queries (%0d empty), %0d results compared,",
                 loads_seen, queries_seen, empty_seen, results_seen);
        $display("over nine register settings with idle mixes and one long receiver hold-off.");
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Timeout
    initial
    begin
        #(10_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
